@@ rtl/jts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jts_pkg
// shared token types, codes and constants of the json token scanner
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] KIND_LBRACE   = 4'd0;
    localparam logic [3:0] KIND_RBRACE   = 4'd1;
    localparam logic [3:0] KIND_LBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_COLON    = 4'd4;
    localparam logic [3:0] KIND_COMMA    = 4'd5;
    localparam logic [3:0] KIND_STRCHAR  = 4'd6;
    localparam logic [3:0] KIND_STREND   = 4'd7;
    localparam logic [3:0] KIND_INT      = 4'd8;
    localparam logic [3:0] KIND_BOOL     = 4'd9;
    localparam logic [3:0] KIND_END      = 4'd10;
    localparam logic [3:0] KIND_ERROR    = 4'd11;

    localparam logic [1:0] ERR_BAD_STRING = 2'd0;
    localparam logic [1:0] ERR_LONE_MINUS = 2'd1;
    localparam logic [1:0] ERR_BAD_BOOL   = 2'd2;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam int TRUE_LEN  = 4;
    localparam int FALSE_LEN = 5;

    // largest magnitude that still takes one more digit without passing 2^63
    localparam logic [63:0] SAT_LIMIT_LOW  = 64'd922337203685477580;
    localparam logic [63:0] SAT_LIMIT_NINE = 64'd922337203685477579;
    localparam logic [63:0] INT_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT_MIN        = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  chr;
        logic [63:0] ival;
        logic        bval;
        logic [1:0]  err;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic [1:0] cnt;
        tok_t       t0;
        tok_t       t1;
    } front_push_t;

    function automatic tok_t mk_tok(input logic [3:0] kind, input logic [7:0] chr,
                                    input logic [63:0] ival, input logic bval,
                                    input logic [1:0] err);
        tok_t t;
        t.kind = kind;
        t.chr  = chr;
        t.ival = ival;
        t.bval = bval;
        t.err  = err;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic logic [7:0] word_char(input logic is_false, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (is_false) begin
            case (pos)
                3'd0: c = 8'h66;
                3'd1: c = 8'h61;
                3'd2: c = 8'h6C;
                3'd3: c = 8'h73;
                3'd4: c = 8'h65;
                default: c = 8'h00;
            endcase
        end else begin
            case (pos)
                3'd0: c = 8'h74;
                3'd1: c = 8'h72;
                3'd2: c = 8'h75;
                3'd3: c = 8'h65;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/jts_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jts_front
// byte classifier and lexer state; turns one request into up to two tokens
// ----------------------------------------------------------------------------
module jts_front
    import jts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        at_end,
    output front_push_t      push
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_INT,
        MODE_TRUE,
        MODE_FALSE
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [2:0]  pos_reg, pos_next;
    logic [63:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic        saw_reg, saw_next;
    logic        sat_reg, sat_next;

    // scan of the byte from the idle state
    logic        idle_emit;
    tok_t        idle_tok;
    mode_t       idle_mode;
    logic [2:0]  idle_pos;
    logic [63:0] idle_mag;
    logic        idle_neg;
    logic        idle_saw;

    always_comb begin
        idle_emit = 1'b0;
        idle_tok  = mk_tok(KIND_ERROR, 8'h00, 64'd0, 1'b0, ERR_UNEXPECTED);
        idle_mode = MODE_IDLE;
        idle_pos  = 3'd0;
        idle_mag  = 64'd0;
        idle_neg  = 1'b0;
        idle_saw  = 1'b0;
        case (in_byte) inside
            CH_SPACE, [CH_TAB:CH_CR]: idle_emit = 1'b0;
            CH_LBRACE: begin
                idle_emit = 1'b1;
                idle_tok  = mk_tok(KIND_LBRACE, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
            end
            CH_RBRACE: begin
                idle_emit = 1'b1;
                idle_tok  = mk_tok(KIND_RBRACE, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
            end
            CH_LBRACKET: begin
                idle_emit = 1'b1;
                idle_tok  = mk_tok(KIND_LBRACKET, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
            end
            CH_RBRACKET: begin
                idle_emit = 1'b1;
                idle_tok  = mk_tok(KIND_RBRACKET, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
            end
            CH_COLON: begin
                idle_emit = 1'b1;
                idle_tok  = mk_tok(KIND_COLON, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
            end
            CH_COMMA: begin
                idle_emit = 1'b1;
                idle_tok  = mk_tok(KIND_COMMA, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
            end
            CH_QUOTE: idle_mode = MODE_STR;
            CH_T: begin
                idle_mode = MODE_TRUE;
                idle_pos  = 3'd1;
            end
            CH_F: begin
                idle_mode = MODE_FALSE;
                idle_pos  = 3'd1;
            end
            CH_MINUS: begin
                idle_mode = MODE_INT;
                idle_neg  = 1'b1;
            end
            [CH_ZERO:CH_NINE]: begin
                idle_mode = MODE_INT;
                idle_mag  = {60'd0, in_byte[3:0]};
                idle_saw  = 1'b1;
            end
            default: idle_emit = 1'b1;
        endcase
    end

    // pending integer as a token
    tok_t        flush_tok;
    logic [63:0] flush_val;

    always_comb begin
        if (neg_reg) begin
            flush_val = sat_reg ? INT_MIN : (~mag_reg + 64'd1);
        end else begin
            flush_val = (sat_reg || mag_reg[63]) ? INT_MAX : mag_reg;
        end
        if (saw_reg) begin
            flush_tok = mk_tok(KIND_INT, 8'h00, flush_val, 1'b0, ERR_BAD_STRING);
        end else begin
            flush_tok = mk_tok(KIND_ERROR, 8'h00, 64'd0, 1'b0, ERR_LONE_MINUS);
        end
    end

    // digit accumulate, times ten as two shifts
    logic        is_digit;
    logic [63:0] sat_limit;
    logic [63:0] mag_acc;

    assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign sat_limit = (in_byte[3:0] == 4'd9) ? SAT_LIMIT_NINE : SAT_LIMIT_LOW;
    assign mag_acc   = {mag_reg[60:0], 3'b000} + {mag_reg[62:0], 1'b0}
                     + {60'd0, in_byte[3:0]};

    // literal matching
    logic        word_hit;
    logic [2:0]  pos_inc;
    logic        word_done;

    assign word_hit  = (in_byte == word_char(mode_reg == MODE_FALSE, pos_reg));
    assign pos_inc   = pos_reg + 3'd1;
    assign word_done = (mode_reg == MODE_FALSE) ? (pos_inc == 3'(FALSE_LEN))
                                                : (pos_inc == 3'(TRUE_LEN));

    tok_t       t0, t1;
    logic [1:0] cnt;
    logic       go_idle;

    always_comb begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        saw_next  = saw_reg;
        sat_next  = sat_reg;
        t0        = mk_tok(KIND_END, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
        t1        = mk_tok(KIND_END, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
        cnt       = 2'd0;
        go_idle   = 1'b0;
        if (at_end) begin
            mode_next = MODE_IDLE;
            pos_next  = 3'd0;
            mag_next  = 64'd0;
            neg_next  = 1'b0;
            saw_next  = 1'b0;
            sat_next  = 1'b0;
            case (mode_reg)
                MODE_STR, MODE_ESC: begin
                    t0  = mk_tok(KIND_ERROR, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
                    cnt = 2'd2;
                end
                MODE_INT: begin
                    t0  = flush_tok;
                    cnt = 2'd2;
                end
                MODE_TRUE, MODE_FALSE: begin
                    t0  = mk_tok(KIND_ERROR, 8'h00, 64'd0, 1'b0, ERR_BAD_BOOL);
                    cnt = 2'd2;
                end
                default: cnt = 2'd1;
            endcase
        end else begin
            case (mode_reg)
                MODE_STR: begin
                    cnt = 2'd1;
                    if (in_byte == CH_QUOTE) begin
                        mode_next = MODE_IDLE;
                        t0 = mk_tok(KIND_STREND, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
                    end else if (in_byte == CH_BACKSLASH) begin
                        mode_next = MODE_ESC;
                        cnt = 2'd0;
                    end else begin
                        t0 = mk_tok(KIND_STRCHAR, in_byte, 64'd0, 1'b0, ERR_BAD_STRING);
                    end
                end
                MODE_ESC: begin
                    if (in_byte == CH_U) begin
                        t0 = mk_tok(KIND_ERROR, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING);
                        go_idle = 1'b1;
                    end else begin
                        mode_next = MODE_STR;
                        t0  = mk_tok(KIND_STRCHAR, in_byte, 64'd0, 1'b0, ERR_BAD_STRING);
                        cnt = 2'd1;
                    end
                end
                MODE_INT: begin
                    if (is_digit) begin
                        saw_next = 1'b1;
                        if (!sat_reg) begin
                            if (mag_reg > sat_limit) begin
                                sat_next = 1'b1;
                            end else begin
                                mag_next = mag_acc;
                            end
                        end
                    end else begin
                        t0 = flush_tok;
                        go_idle = 1'b1;
                    end
                end
                MODE_TRUE, MODE_FALSE: begin
                    if (word_hit) begin
                        pos_next = pos_inc;
                        if (word_done) begin
                            mode_next = MODE_IDLE;
                            pos_next  = 3'd0;
                            t0  = mk_tok(KIND_BOOL, 8'h00, 64'd0,
                                         mode_reg == MODE_TRUE, ERR_BAD_STRING);
                            cnt = 2'd1;
                        end
                    end else begin
                        t0 = mk_tok(KIND_ERROR, 8'h00, 64'd0, 1'b0, ERR_BAD_BOOL);
                        go_idle = 1'b1;
                    end
                end
                default: begin
                    mode_next = idle_mode;
                    pos_next  = idle_pos;
                    mag_next  = idle_mag;
                    neg_next  = idle_neg;
                    saw_next  = idle_saw;
                    sat_next  = 1'b0;
                    t0  = idle_tok;
                    cnt = {1'b0, idle_emit};
                end
            endcase
            if (go_idle) begin
                mode_next = idle_mode;
                pos_next  = idle_pos;
                mag_next  = idle_mag;
                neg_next  = idle_neg;
                saw_next  = idle_saw;
                sat_next  = 1'b0;
                t1  = idle_tok;
                cnt = idle_emit ? 2'd2 : 2'd1;
            end
        end
        if (cnt == 2'd1) begin
            t0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            t1.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= 3'd0;
            mag_reg  <= 64'd0;
            neg_reg  <= 1'b0;
            saw_reg  <= 1'b0;
            sat_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            saw_reg  <= saw_next;
            sat_reg  <= sat_next;
        end
    end

    assign push.cnt = accept ? cnt : 2'd0;
    assign push.t0  = t0;
    assign push.t1  = t1;

endmodule
`default_nettype wire

@@ rtl/jts_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jts_queue
// short token queue, takes up to two tokens and gives one per cycle while popped
// ----------------------------------------------------------------------------
module jts_queue
    import jts_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire front_push_t  push,
    input  wire logic         pop,
    output tok_t              head,
    output logic              head_valid,
    output logic [LEVEL_W-1:0] level
);

    tok_t               mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [PTR_W-1:0]   wr_ptr_plus;
    logic               do_pop;

    assign do_pop      = pop && (level_reg != '0);
    assign wr_ptr_plus = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
    assign level_next  = level_reg + LEVEL_W'(push.cnt) - LEVEL_W'(do_pop);

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.t0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_plus] <= push.t1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign level      = level_reg;

endmodule
`default_nettype wire

@@ rtl/jts_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jts_back
// output register of the token channel, loads from the queue head
// ----------------------------------------------------------------------------
module jts_back
    import jts_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire tok_t         head,
    input  wire logic         head_valid,
    output logic              pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [79:0]       m_tdata,
    output logic [3:0]        m_tuser,
    output logic              m_tlast
);

    logic valid_reg;
    tok_t tok_reg;

    assign pop = head_valid && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            tok_reg <= head;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, tok_reg.err, tok_reg.bval, tok_reg.ival, tok_reg.chr};
    assign m_tuser  = tok_reg.kind;
    assign m_tlast  = tok_reg.last;

endmodule
`default_nettype wire

@@ rtl/json_token_scanner_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// json_token_scanner_top
// streaming json lexer, one byte per request in, one token per request out
// ----------------------------------------------------------------------------
// input channel: s_tdata[7:0] carries a byte, s_tlast marks end of input
// (the byte is then ignored, any pending token is flushed, an end token
// follows). output channel: one token per request, m_tuser is the kind,
// m_tlast marks the final token caused by an input request.
// path: a token caused by an accepted byte is written into the token queue,
// then loaded into the output register, which drives m_tvalid.
// throughput: one byte per cycle while m_tready is high and each byte gives
// at most one token; the output register moves one token per cycle, so bytes
// that give two tokens (an end marker inside a token, an integer or broken
// literal ended by a token byte, a \u escape) can fill the queue and stall input.
// the four-entry token queue sets the input stall: s_tready is low while
// fewer than two entries are free.
// reset: synchronous, clears lexer state, queue and output valid.
// a stalled receiver holds the output register, then fills the queue to
// more than two entries, and then s_tready drops; no token is lost.
// ----------------------------------------------------------------------------
module json_token_scanner_top
    import jts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic        s_tlast,   // at_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // tok_char, int_value, bool_value, err_code
    output logic [3:0]       m_tuser,   // tok_kind
    output logic             m_tlast    // last
);

    front_push_t        push;
    tok_t               head;
    logic               head_valid;
    logic               pop;
    logic [LEVEL_W-1:0] q_level;
    logic               accept;

    assign s_tready = (q_level <= LEVEL_W'(QUEUE_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;

    jts_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_tdata),
        .at_end  (s_tlast),
        .push    (push)
    );

    jts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .level      (q_level)
    );

    jts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= LEVEL_W'(QUEUE_DEPTH))
        else $error("token queue overflow");

    a_end_makes_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (q_level != '0 || m_tvalid))
        else $error("end request produced no token");

    a_accept_has_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |-> (push.cnt != 2'd0))
        else $error("end request pushed nothing");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for json_token_scanner_top: a directed table of bytes
// and end markers, then random json-like lexemes (structurals, strings with
// escapes, integers up to and past the 64-bit limits, true/false literals,
// broken sequences and noise), each token checked against a built-in lexer or,
// for a fixed table row, against the token that the row gives
module tb;
    import jts_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 720;
    localparam int CALM_FROM   = 650;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_STRING,
        LX_ESCAPE,
        LX_NUMBER,
        LX_TRUE,
        LX_FALSE
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       at_end;
        logic       fixed;
        logic [3:0] kind;
        logic [1:0] err;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;   // tok_char, int_value, bool_value, err_code
    logic [3:0]  m_tuser;   // tok_kind
    logic        m_tlast;

    // lexer state of the predictor
    lex_mode_t   lx_mode;
    logic [2:0]  lx_pos;
    logic [63:0] lx_mag;
    logic        lx_neg;
    logic        lx_digit;
    logic        lx_sat;

    tok_t        step_tokens[$];
    tok_t        pending_tokens[$];
    stim_row_t   directed_rows[$];

    bit          idle_on = 1'b1;
    bit          hold_request = 1'b0;
    int          fail_count = 0;
    int          random_items = 0;
    int          tokens_checked = 0;
    int          ints_checked = 0;
    int          errors_checked = 0;
    int          stall_cycles = 0;

    tok_t        seen;
    tok_t        want;
    tok_t        fixed_tok;
    int          pick;
    int          k;
    int          len;
    int          cut;
    string       text;
    logic [7:0]  c;

    always #4 aclk = ~aclk;

    json_token_scanner_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic tok_t token_of(input logic [3:0] kind, input logic [7:0] chr,
                                      input logic [63:0] ival, input logic bval,
                                      input logic [1:0] err);
        tok_t t;
        t.kind = kind;
        t.chr  = chr;
        t.ival = ival;
        t.bval = bval;
        t.err  = err;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic string tok_text(input tok_t t);
        return $sformatf("kind %0d chr %h int %h bool %b err %0d last %b",
                         t.kind, t.chr, t.ival, t.bval, t.err, t.last);
    endfunction

    function automatic void lex_reset();
        lx_mode  = LX_IDLE;
        lx_pos   = 3'd0;
        lx_mag   = 64'd0;
        lx_neg   = 1'b0;
        lx_digit = 1'b0;
        lx_sat   = 1'b0;
    endfunction

    function automatic void lex_flush_number();
        logic [63:0] v;
        if (!lx_digit) begin
            step_tokens.push_back(token_of(KIND_ERROR, 8'h00, 64'd0, 1'b0, ERR_LONE_MINUS));
        end else begin
            if (lx_neg)
                v = lx_sat ? INT_MIN : -lx_mag;
            else
                v = (lx_sat || lx_mag > INT_MAX) ? INT_MAX : lx_mag;
            step_tokens.push_back(token_of(KIND_INT, 8'h00, v, 1'b0, ERR_BAD_STRING));
        end
        lex_reset();
    endfunction

    function automatic void lex_idle(input logic [7:0] b);
        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
            lx_mode = LX_IDLE;
        end else if (b == CH_LBRACE) begin
            step_tokens.push_back(token_of(KIND_LBRACE, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING));
        end else if (b == CH_RBRACE) begin
            step_tokens.push_back(token_of(KIND_RBRACE, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING));
        end else if (b == CH_LBRACKET) begin
            step_tokens.push_back(token_of(KIND_LBRACKET, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING));
        end else if (b == CH_RBRACKET) begin
            step_tokens.push_back(token_of(KIND_RBRACKET, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING));
        end else if (b == CH_COLON) begin
            step_tokens.push_back(token_of(KIND_COLON, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING));
        end else if (b == CH_COMMA) begin
            step_tokens.push_back(token_of(KIND_COMMA, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING));
        end else if (b == CH_QUOTE) begin
            lx_mode = LX_STRING;
        end else if (b == CH_T) begin
            lx_mode = LX_TRUE;
            lx_pos  = 3'd1;
        end else if (b == CH_F) begin
            lx_mode = LX_FALSE;
            lx_pos  = 3'd1;
        end else if (b == CH_MINUS || (b >= CH_ZERO && b <= CH_NINE)) begin
            lex_reset();
            lx_mode = LX_NUMBER;
            if (b == CH_MINUS) begin
                lx_neg = 1'b1;
            end else begin
                lx_mag   = {56'd0, b - CH_ZERO};
                lx_digit = 1'b1;
            end
        end else begin
            step_tokens.push_back(token_of(KIND_ERROR, 8'h00, 64'd0, 1'b0, ERR_UNEXPECTED));
        end
    endfunction

    function automatic void lex_word(input logic [7:0] b);
        string w;
        logic  is_false;
        is_false = (lx_mode == LX_FALSE);
        if (is_false)
            w = "false";
        else
            w = "true";
        if (lx_pos < w.len() && b == w[lx_pos]) begin
            lx_pos = lx_pos + 3'd1;
            if (lx_pos >= w.len()) begin
                lex_reset();
                step_tokens.push_back(token_of(KIND_BOOL, 8'h00, 64'd0, !is_false,
                                               ERR_BAD_STRING));
            end
        end else begin
            lex_reset();
            step_tokens.push_back(token_of(KIND_ERROR, 8'h00, 64'd0, 1'b0, ERR_BAD_BOOL));
            lex_idle(b);
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] b, input logic at_end);
        logic [63:0] d;
        tok_t        t;
        step_tokens.delete();
        if (at_end) begin
            case (lx_mode)
                LX_STRING, LX_ESCAPE: begin
                    step_tokens.push_back(token_of(KIND_ERROR, 8'h00, 64'd0, 1'b0,
                                                   ERR_BAD_STRING));
                end
                LX_NUMBER: begin
                    lex_flush_number();
                end
                LX_TRUE, LX_FALSE: begin
                    step_tokens.push_back(token_of(KIND_ERROR, 8'h00, 64'd0, 1'b0,
                                                   ERR_BAD_BOOL));
                end
                default: ;
            endcase
            lex_reset();
            step_tokens.push_back(token_of(KIND_END, 8'h00, 64'd0, 1'b0, ERR_BAD_STRING));
        end else begin
            case (lx_mode)
                LX_STRING: begin
                    if (b == CH_QUOTE) begin
                        lx_mode = LX_IDLE;
                        step_tokens.push_back(token_of(KIND_STREND, 8'h00, 64'd0, 1'b0,
                                                       ERR_BAD_STRING));
                    end else if (b == CH_BACKSLASH) begin
                        lx_mode = LX_ESCAPE;
                    end else begin
                        step_tokens.push_back(token_of(KIND_STRCHAR, b, 64'd0, 1'b0,
                                                       ERR_BAD_STRING));
                    end
                end
                LX_ESCAPE: begin
                    if (b == CH_U) begin
                        lex_reset();
                        step_tokens.push_back(token_of(KIND_ERROR, 8'h00, 64'd0, 1'b0,
                                                       ERR_BAD_STRING));
                        lex_idle(b);
                    end else begin
                        lx_mode = LX_STRING;
                        step_tokens.push_back(token_of(KIND_STRCHAR, b, 64'd0, 1'b0,
                                                       ERR_BAD_STRING));
                    end
                end
                LX_NUMBER: begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        d = {56'd0, b - CH_ZERO};
                        lx_digit = 1'b1;
                        if (!lx_sat) begin
                            if (lx_mag > (INT_MIN - d) / 64'd10)
                                lx_sat = 1'b1;
                            else
                                lx_mag = lx_mag * 64'd10 + d;
                        end
                    end else begin
                        lex_flush_number();
                        lex_idle(b);
                    end
                end
                LX_TRUE, LX_FALSE: begin
                    lex_word(b);
                end
                default: begin
                    lex_idle(b);
                end
            endcase
        end
        if (step_tokens.size() != 0) begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
    endfunction

    function automatic void row_checked(input logic [7:0] data, input logic at_end);
        stim_row_t r;
        r.data   = data;
        r.at_end = at_end;
        r.fixed  = 1'b0;
        r.kind   = KIND_END;
        r.err    = ERR_BAD_STRING;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_fixed(input logic [7:0] data, input logic at_end,
                                      input logic [3:0] kind, input logic [1:0] err);
        stim_row_t r;
        r.data   = data;
        r.at_end = at_end;
        r.fixed  = 1'b1;
        r.kind   = kind;
        r.err    = err;
        directed_rows.push_back(r);
    endfunction

    task automatic offer(input logic [7:0] b, input logic at_end);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= at_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic feed(input logic [7:0] b, input logic at_end);
        scan_byte(b, at_end);
        foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
        random_items++;
        if (random_items >= CALM_FROM)
            idle_on = 1'b0;
        offer(b, at_end);
    endtask

    // token checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.kind = m_tuser;
            seen.chr  = m_tdata[7:0];
            seen.ival = m_tdata[71:8];
            seen.bval = m_tdata[72];
            seen.err  = m_tdata[74:73];
            seen.last = m_tlast;
            if (pending_tokens.size() == 0) begin
                $display("%0t unexpected token: %s", $time, tok_text(seen));
                fail_count++;
            end else begin
                want = pending_tokens.pop_front();
                if (seen !== want) begin
                    $display("%0t token mismatch: expected %s, got %s", $time,
                             tok_text(want), tok_text(seen));
                    fail_count++;
                end
                tokens_checked++;
                if (want.kind == KIND_INT)
                    ints_checked++;
                if (want.kind == KIND_ERROR)
                    errors_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("%0t no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL json_token_scanner_top");
                $finish;
            end
        end
    end

    // token receiver
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        lex_reset();
        row_fixed(CH_LBRACE, 1'b0, KIND_LBRACE, ERR_BAD_STRING);
        row_fixed(CH_RBRACE, 1'b0, KIND_RBRACE, ERR_BAD_STRING);
        row_fixed(CH_LBRACKET, 1'b0, KIND_LBRACKET, ERR_BAD_STRING);
        row_fixed(CH_RBRACKET, 1'b0, KIND_RBRACKET, ERR_BAD_STRING);
        row_fixed(CH_COLON, 1'b0, KIND_COLON, ERR_BAD_STRING);
        row_fixed(CH_COMMA, 1'b0, KIND_COMMA, ERR_BAD_STRING);
        row_checked(8'h0B, 1'b0);
        row_fixed(8'h80, 1'b0, KIND_ERROR, ERR_UNEXPECTED);
        row_checked(CH_QUOTE, 1'b0);
        row_checked(8'hFF, 1'b0);
        row_checked(CH_QUOTE, 1'b0);
        row_checked(CH_QUOTE, 1'b0);
        row_checked(CH_BACKSLASH, 1'b0);
        row_checked(CH_U, 1'b0);
        row_checked(CH_MINUS, 1'b0);
        row_checked(CH_COMMA, 1'b0);
        row_checked(CH_T, 1'b0);
        row_checked(8'h72, 1'b0);
        row_checked(CH_U, 1'b0);
        row_checked(8'h65, 1'b0);
        row_checked(CH_F, 1'b0);
        row_checked(8'h78, 1'b0);
        row_checked(CH_F, 1'b0);
        row_checked(8'h00, 1'b1);
        row_checked(8'h37, 1'b0);
        row_checked(8'hFF, 1'b1);
        row_checked(CH_QUOTE, 1'b0);
        row_checked(8'h00, 1'b1);
        row_fixed(8'h5A, 1'b1, KIND_END, ERR_BAD_STRING);
        row_fixed(8'h00, 1'b0, KIND_ERROR, ERR_UNEXPECTED);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            scan_byte(directed_rows[i].data, directed_rows[i].at_end);
            if (directed_rows[i].fixed) begin
                fixed_tok = token_of(directed_rows[i].kind, 8'h00, 64'd0, 1'b0,
                                     directed_rows[i].err);
                fixed_tok.last = 1'b1;
                pending_tokens.push_back(fixed_tok);
            end else begin
                foreach (step_tokens[j]) pending_tokens.push_back(step_tokens[j]);
            end
            offer(directed_rows[i].data, directed_rows[i].at_end);
        end

        // receiver stalls long enough to back up the queue into s_tready
        hold_request = 1'b1;

        while (random_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                case ($urandom_range(0, 5))
                    0: c = CH_LBRACE;
                    1: c = CH_RBRACE;
                    2: c = CH_LBRACKET;
                    3: c = CH_RBRACKET;
                    4: c = CH_COLON;
                    default: c = CH_COMMA;
                endcase
                feed(c, 1'b0);
            end else if (pick < 30) begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 1) == 0)
                        c = CH_SPACE;
                    else
                        c = CH_TAB + 8'($urandom_range(0, 4));
                    feed(c, 1'b0);
                end
            end else if (pick < 50) begin
                len = $urandom_range(0, 6);
                feed(CH_QUOTE, 1'b0);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 6) == 0) begin
                        feed(CH_BACKSLASH, 1'b0);
                        c = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 9) == 0)
                            c = CH_U;
                        feed(c, 1'b0);
                    end else begin
                        c = 8'($urandom_range(0, 255));
                        while (c == CH_QUOTE || c == CH_BACKSLASH)
                            c = 8'($urandom_range(0, 255));
                        feed(c, 1'b0);
                    end
                end
                if ($urandom_range(0, 9) != 0)
                    feed(CH_QUOTE, 1'b0);
            end else if (pick < 70) begin
                if ($urandom_range(0, 2) == 0)
                    feed(CH_MINUS, 1'b0);
                case ($urandom_range(0, 3))
                    0: begin
                        len = $urandom_range(1, 4);
                        for (k = 0; k < len; k++) begin
                            c = CH_ZERO + 8'($urandom_range(0, 9));
                            feed(c, 1'b0);
                        end
                    end
                    1: begin
                        len = $urandom_range(15, 22);
                        for (k = 0; k < len; k++) begin
                            c = CH_ZERO + 8'($urandom_range((k == 0) ? 1 : 0, 9));
                            feed(c, 1'b0);
                        end
                    end
                    default: begin
                        case ($urandom_range(0, 6))
                            0: text = "9223372036854775807";
                            1: text = "9223372036854775808";
                            2: text = "9223372036854775809";
                            3: text = "922337203685477580";
                            4: text = "99999999999999999999";
                            5: text = "0";
                            default: text = "00012";
                        endcase
                        for (k = 0; k < text.len(); k++)
                            feed(text[k], 1'b0);
                    end
                endcase
            end else if (pick < 80) begin
                if ($urandom_range(0, 1) == 0)
                    text = "true";
                else
                    text = "false";
                cut = text.len();
                if ($urandom_range(0, 5) == 0)
                    cut = $urandom_range(1, text.len() - 1);
                for (k = 0; k < cut; k++)
                    feed(text[k], 1'b0);
                if (cut < text.len()) begin
                    c = 8'($urandom_range(0, 255));
                    feed(c, 1'b0);
                end
            end else if (pick < 85) begin
                feed(CH_MINUS, 1'b0);
            end else if (pick < 95) begin
                c = 8'($urandom_range(0, 255));
                feed(c, 1'b0);
            end else begin
                c = 8'($urandom_range(0, 255));
                feed(c, 1'b1);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("run: %0d table requests, %0d random requests, one long output stall",
                 directed_rows.size(), random_items);
        $display("checked %0d tokens: %0d integers, %0d errors, %0d mismatches",
                 tokens_checked, ints_checked, errors_checked, fail_count);
        if (fail_count == 0)
            $display("PASS json_token_scanner_top");
        else
            $display("FAIL json_token_scanner_top");
        $finish;
    end

endmodule

@@ json_token_scanner_top.f @@
rtl/jts_pkg.sv
rtl/jts_front.sv
rtl/jts_queue.sv
rtl/jts_back.sv
rtl/json_token_scanner_top.sv
tb/sv/tb.sv
